// ===== hdl/ptm_pkg.sv =====
package ptm_pkg;

   // Pool and geometry
   localparam int TABLE_POOL = 16;
   localparam int DIR_SIZE   = 1024;
   localparam int IDX_W      = $clog2(DIR_SIZE);
   localparam int DIR_SHIFT  = 22;
   localparam int TBL_SHIFT  = 12;
   localparam int SLOT_W     = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
   localparam int CNT_W      = $clog2(TABLE_POOL + 1);
   localparam int TBL_DEPTH  = TABLE_POOL * DIR_SIZE;
   localparam int TBL_AW     = $clog2(TBL_DEPTH);

   localparam logic [31:0] FRAME_MASK       = 32'hFFFF_F000;
   localparam logic [31:0] ENTRY_PRESENT_RW = 32'h0000_0003;

   // Operation codes
   localparam logic [1:0] OP_MAP   = 2'd0;
   localparam logic [1:0] OP_UNMAP = 2'd1;
   localparam logic [1:0] OP_XLATE = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOMEM  = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] virt_addr_in;
      logic [31:0] phys_addr_in;
      logic [11:0] page_flags;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] phys_addr_out;
   } rsp_type;

   // Directory entry as stored in the directory memory
   typedef struct packed {
      logic              present;
      logic [SLOT_W-1:0] slot;
   } dir_entry_type;

   // Directory memory access, one address for read and write
   typedef struct packed {
      logic             wr_en;
      logic             rd_en;
      logic [IDX_W-1:0] addr;
      dir_entry_type    wdata;
   } dir_req_type;

   // Page table memory access
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [TBL_AW-1:0] addr;
      logic [31:0]       wdata;
   } tbl_req_type;

   // Flat table address from pool slot and table index
   function automatic logic [TBL_AW-1:0] tbl_index(input logic [SLOT_W-1:0] slot,
                                                  input logic [IDX_W-1:0] idx);
      logic [SLOT_W+IDX_W-1:0] full;
      full = {slot, idx};
      return full[TBL_AW-1:0];
   endfunction

endpackage

// ===== hdl/ptm_ram.sv =====
module ptm_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/ptm_ctrl.sv =====
module ptm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ptm_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ptm_pkg::rsp_type      rsp_data,
   output ptm_pkg::dir_req_type  dir_req,
   input  ptm_pkg::dir_entry_type dir_rdata,
   output ptm_pkg::tbl_req_type  tbl_req,
   input  logic [31:0]           tbl_rdata
);
   import ptm_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_DIR,
      S_CLEAR,
      S_TRD,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   req_type           item_ff, item_in;
   logic [IDX_W-1:0]  init_cnt_ff, init_cnt_in;
   logic [IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  next_free_ff, next_free_in;
   logic [1:0]        status_ff, status_in;
   logic [31:0]       result_ff, result_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]  tidx;
   logic [31:0]       map_val;

   assign tidx    = item_ff.virt_addr_in[TBL_SHIFT +: IDX_W];
   assign map_val = item_ff.phys_addr_in | {20'd0, item_ff.page_flags} | ENTRY_PRESENT_RW;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      init_cnt_in  = init_cnt_ff;
      clr_cnt_in   = clr_cnt_ff;
      slot_in      = slot_ff;
      next_free_in = next_free_ff;
      status_in    = status_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      dir_req      = '0;
      tbl_req      = '0;

      unique case (state_ff)
         S_INIT: begin
            // sweep the directory clear after reset
            dir_req.wr_en = 1'b1;
            dir_req.addr  = init_cnt_ff;
            init_cnt_in   = init_cnt_ff + 1'b1;
            if (init_cnt_ff == IDX_W'(DIR_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               item_in       = req_data;
               dir_req.rd_en = 1'b1;
               dir_req.addr  = req_data.virt_addr_in[DIR_SHIFT +: IDX_W];
               state_in      = S_DIR;
            end
         end
         S_DIR: begin
            status_in = ST_OK;
            result_in = '0;
            state_in  = S_RESP;
            dir_req.addr = item_ff.virt_addr_in[DIR_SHIFT +: IDX_W];
            unique case (item_ff.opcode)
               OP_MAP: begin
                  if (dir_rdata.present) begin
                     tbl_req.wr_en = 1'b1;
                     tbl_req.addr  = tbl_index(dir_rdata.slot, tidx);
                     tbl_req.wdata = map_val;
                  end else if (next_free_ff == CNT_W'(TABLE_POOL)) begin
                     status_in = ST_NOMEM;
                  end else begin
                     // take a new table; the clear sweep also drops in the entry
                     slot_in               = next_free_ff[SLOT_W-1:0];
                     next_free_in          = next_free_ff + 1'b1;
                     dir_req.wr_en         = 1'b1;
                     dir_req.wdata.present = 1'b1;
                     dir_req.wdata.slot    = next_free_ff[SLOT_W-1:0];
                     clr_cnt_in            = '0;
                     state_in              = S_CLEAR;
                  end
               end
               OP_UNMAP: begin
                  if (!dir_rdata.present) begin
                     status_in = ST_ABSENT;
                  end else begin
                     tbl_req.wr_en = 1'b1;
                     tbl_req.addr  = tbl_index(dir_rdata.slot, tidx);
                  end
               end
               OP_XLATE: begin
                  if (!dir_rdata.present) begin
                     status_in = ST_ABSENT;
                  end else begin
                     tbl_req.rd_en = 1'b1;
                     tbl_req.addr  = tbl_index(dir_rdata.slot, tidx);
                     state_in      = S_TRD;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_CLEAR: begin
            tbl_req.wr_en = 1'b1;
            tbl_req.addr  = tbl_index(slot_ff, clr_cnt_ff);
            tbl_req.wdata = (clr_cnt_ff == tidx) ? map_val : 32'd0;
            clr_cnt_in    = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == IDX_W'(DIR_SIZE - 1)) begin
               state_in = S_RESP;
            end
         end
         S_TRD: begin
            result_in = tbl_rdata & FRAME_MASK;
            state_in  = S_RESP;
         end
         S_RESP: begin
            // load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.phys_addr_out = result_ff;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_cnt_ff  <= '0;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      clr_cnt_ff  <= clr_cnt_in;
      slot_ff     <= slot_in;
      status_ff   <= status_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/two_level_page_table_manager_top.sv =====
// Two-level page table manager.
// Input channel (req_valid / req_stall / req_data): one beat is one operation:
//   map, unmap or translate, on a 32-bit virtual address (directory index in
//   bits 31..22, table index in bits 21..12).
// Result channel (rsp_valid / rsp_stall / rsp_data): exactly one beat per
//   operation, carrying status and, for translate, the frame address.
// From input beat to result beat, every operation reads the directory and then
//   loads the output register once it is free; translate also reads the page
//   table before that, and a map that takes a new table first runs the
//   one-entry-per-cycle clear of that table through the table memory port.
// One operation is in flight at a time; both memories are single ported.
//   A new input beat is taken only once the last operation has loaded its result.
// After reset the directory memory is swept clear, all 1024 entries, while
//   req_stall is high.
// A result waits in the output register while rsp_stall is high; the next
//   input beat is still taken, and its result is held back until the
//   register frees up.
module two_level_page_table_manager_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptm_pkg::rsp_type rsp_data
);
   import ptm_pkg::*;

   dir_req_type   dir_req;
   dir_entry_type dir_rdata;
   tbl_req_type   tbl_req;
   logic [31:0]   tbl_rdata;

   ptm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .dir_req   (dir_req),
      .dir_rdata (dir_rdata),
      .tbl_req   (tbl_req),
      .tbl_rdata (tbl_rdata)
   );

   // Page directory: present bit and pool slot
   ptm_ram #(
      .DEPTH (DIR_SIZE),
      .WIDTH (SLOT_W + 1)
   ) u_dir_ram (
      .clock (clock),
      .wr_en (dir_req.wr_en),
      .rd_en (dir_req.rd_en),
      .addr  (dir_req.addr),
      .wdata (dir_req.wdata),
      .rdata (dir_rdata)
   );

   // Page table pool
   ptm_ram #(
      .DEPTH (TBL_DEPTH),
      .WIDTH (32)
   ) u_tbl_ram (
      .clock (clock),
      .wr_en (tbl_req.wr_en),
      .rd_en (tbl_req.rd_en),
      .addr  (tbl_req.addr),
      .wdata (tbl_req.wdata),
      .rdata (tbl_rdata)
   );

endmodule

// ===== hdl/ptm_checker.sv =====
module ptm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ptm_pkg::rsp_type rsp_data
);
   import ptm_pkg::*;

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // No result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat after reset");

   // Failed operations return no address
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.phys_addr_out == 32'd0)
      else $error("address on failed operation");

   // Returned addresses are page aligned
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.phys_addr_out[11:0] == 12'd0)
      else $error("unaligned frame address");

   // An accepted beat stalls the input while it is worked on
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat taken while busy");

endmodule

bind two_level_page_table_manager_top ptm_checker u_ptm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
